// ===== rtl/escape_time_fractal_pixel_assert.svh =====
// Assertion macros used by the escape-time pixel controller (etfp_ctrl).
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_ASSERT_SVH

// Same-cycle implication.
`define ETFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ETFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/etfp_pkg.sv =====
// Shared types and constants for the escape-time pixel block.
// No dependencies.
package etfp_pkg;

  localparam int FRAC_BITS_DEF  = 28;
  localparam int PIXEL_BITS_DEF = 11;
  localparam int PIX_PORT_W     = 11;
  localparam int PIX_MAX_W      = 14;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_RE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IM    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRACTAL_KIND = 3'd5;

  localparam logic [30:0]        RST_PIXEL_STEP   = 31'd958698;
  localparam logic signed [31:0] RST_ORIGIN_RE    = -32'sd239674514;
  localparam logic signed [31:0] RST_ORIGIN_IM    = -32'sd119837257;
  localparam logic [30:0]        RST_ESCAPE_LIMIT = 31'd1073741824;
  localparam logic [7:0]         RST_MAX_ITER     = 8'd255;
  localparam logic               RST_FRACTAL_KIND = 1'b0;

  localparam logic [7:0] PAL_RED   = 8'd30;
  localparam logic [7:0] PAL_GREEN = 8'd10;
  localparam logic [7:0] PAL_BLUE  = 8'd15;

  typedef struct packed {
    logic [30:0]        pixel_step;
    logic signed [31:0] origin_re;
    logic signed [31:0] origin_im;
    logic [30:0]        escape_limit;
    logic [7:0]         max_iter;
    logic               fractal_kind;
  } etfp_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic map_mul;
    logic map_add;
    logic sq_mul;
    logic update;
  } etfp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stop;
  } etfp_sts_t;

endpackage

// ===== rtl/escape_time_fractal_pixel.sv =====
// Escape-time fractal pixel unit (Mandelbrot / Burning Ship).
// Channels: start_i/busy_o take one pixel (pixel_x_i, pixel_y_i); a transfer
//   happens at a rising edge with start_i high and busy_o low.
// Results: done_o pulses for one cycle with iterations_o, escaped_o and the
//   palette colour red_o/green_o/blue_o; the receiver cannot stall, so the
//   result must be taken in that cycle.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   cfg_ready_o is always high. Write only while busy_o is low.
// Sequence: the pixel is first mapped to c (multiply, then add and
//   saturate), then each iteration passes through the shared complex-square
//   unit (square products, then escape test and update). A new start is
//   taken in the strobe cycle.
// Reset: asynchronous, active low; the controller returns to idle and
//   the configuration registers take their documented defaults (4.0 escape limit, 255 steps).
// Depends on etfp_pkg, etfp_cfg, etfp_datapath and etfp_ctrl.
module escape_time_fractal_pixel #(
  parameter int FRAC_BITS  = etfp_pkg::FRAC_BITS_DEF,
  parameter int PIXEL_BITS = etfp_pkg::PIXEL_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [etfp_pkg::PIX_PORT_W-1:0] pixel_x_i,
  input  logic [etfp_pkg::PIX_PORT_W-1:0] pixel_y_i,
  output logic                            done_o,
  output logic [7:0]                      iterations_o,
  output logic                            escaped_o,
  output logic [7:0]                      red_o,
  output logic [7:0]                      green_o,
  output logic [7:0]                      blue_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [etfp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [etfp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import etfp_pkg::*;

  etfp_cfg_t cfg;
  etfp_cmd_t cmd;
  etfp_sts_t sts;

  etfp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  etfp_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .iterations_o (iterations_o),
    .escaped_o    (escaped_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  etfp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

endmodule

// ===== rtl/etfp_cfg.sv =====
// Configuration register file for the escape-time pixel block.
// Depends on etfp_pkg.
module etfp_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [etfp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [etfp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output etfp_pkg::etfp_cfg_t                cfg_o
);
  import etfp_pkg::*;

  etfp_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PIXEL_STEP:   cfg_d.pixel_step   = cfg_data_i[30:0];
        REG_ORIGIN_RE:    cfg_d.origin_re    = $signed(cfg_data_i);
        REG_ORIGIN_IM:    cfg_d.origin_im    = $signed(cfg_data_i);
        REG_ESCAPE_LIMIT: cfg_d.escape_limit = cfg_data_i[30:0];
        REG_MAX_ITER:     cfg_d.max_iter     = cfg_data_i[7:0];
        REG_FRACTAL_KIND: cfg_d.fractal_kind = cfg_data_i[0];
        default:          cfg_d = cfg_q;  // drop writes to unmapped indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_step   <= RST_PIXEL_STEP;
      cfg_q.origin_re    <= RST_ORIGIN_RE;
      cfg_q.origin_im    <= RST_ORIGIN_IM;
      cfg_q.escape_limit <= RST_ESCAPE_LIMIT;
      cfg_q.max_iter     <= RST_MAX_ITER;
      cfg_q.fractal_kind <= RST_FRACTAL_KIND;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/etfp_datapath.sv =====
// Datapath: pixel-to-point mapping and the complex-square iteration unit.
// Depends on etfp_pkg; driven by etfp_ctrl commands.
module etfp_datapath #(
  parameter int FRAC_BITS  = etfp_pkg::FRAC_BITS_DEF,
  parameter int PIXEL_BITS = etfp_pkg::PIXEL_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic [etfp_pkg::PIX_PORT_W-1:0]   pixel_x_i,
  input  logic [etfp_pkg::PIX_PORT_W-1:0]   pixel_y_i,
  input  etfp_pkg::etfp_cfg_t               cfg_i,
  input  etfp_pkg::etfp_cmd_t               cmd_i,
  output etfp_pkg::etfp_sts_t               sts_o,
  output logic [7:0]                        iterations_o,
  output logic                              escaped_o,
  output logic [7:0]                        red_o,
  output logic [7:0]                        green_o,
  output logic [7:0]                        blue_o
);
  import etfp_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic [PIX_MAX_W-1:0]  px_ext, py_ext;
  logic [PIXEL_BITS-1:0] px_q, py_q;

  logic signed [31:0] cr_q, ci_q, zr_q, zi_q;
  logic [7:0]         n_q;
  logic [7:0]         iter_q;
  logic               esc_q;

  logic signed [32:0] m0a, m0b, m1a, m1b, m2a, m2b;
  logic signed [65:0] m0_full, m1_full, m2_full;
  logic signed [63:0] p0_q, p1_q, p2_q;

  logic signed [63:0] map_re, map_im;
  logic [63:0]        mag_sum, mag;
  logic               esc;
  logic signed [63:0] diff, ri_abs, nr_sum, ni_sum;

  assign px_ext = {{(PIX_MAX_W-PIX_PORT_W){1'b0}}, pixel_x_i};
  assign py_ext = {{(PIX_MAX_W-PIX_PORT_W){1'b0}}, pixel_y_i};

  // Share two of the multipliers between point mapping and squaring.
  always_comb begin
    if (cmd_i.map_mul) begin
      m0a = $signed({{(33-PIXEL_BITS){1'b0}}, px_q});
      m0b = $signed({2'b00, cfg_i.pixel_step});
      m1a = $signed({{(33-PIXEL_BITS){1'b0}}, py_q});
      m1b = $signed({2'b00, cfg_i.pixel_step});
    end else begin
      m0a = $signed({zr_q[31], zr_q});
      m0b = $signed({zr_q[31], zr_q});
      m1a = $signed({zi_q[31], zi_q});
      m1b = $signed({zi_q[31], zi_q});
    end
    m2a = $signed({zr_q[31], zr_q});
    m2b = $signed({zi_q[31], zi_q});
  end

  assign m0_full = m0a * m0b;
  assign m1_full = m1a * m1b;
  assign m2_full = m2a * m2b;

  assign map_re = $signed({{32{cfg_i.origin_re[31]}}, cfg_i.origin_re}) + p0_q;
  assign map_im = $signed({{32{cfg_i.origin_im[31]}}, cfg_i.origin_im}) + p1_q;

  // Escape test on the current z; squares are never negative.
  assign mag_sum = $unsigned(p0_q) + $unsigned(p1_q);
  assign mag     = mag_sum >> FRAC_BITS;
  assign esc     = mag > {33'd0, cfg_i.escape_limit};

  assign diff   = p0_q - p1_q;
  assign ri_abs = (cfg_i.fractal_kind && p2_q[63]) ? -p2_q : p2_q;
  assign nr_sum = (diff >>> FRAC_BITS) + $signed({{32{cr_q[31]}}, cr_q});
  assign ni_sum = (ri_abs >>> (FRAC_BITS - 1)) + $signed({{32{ci_q[31]}}, ci_q});

  assign sts_o.stop = esc || (n_q == cfg_i.max_iter);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q <= px_ext[PIXEL_BITS-1:0];
      py_q <= py_ext[PIXEL_BITS-1:0];
    end
    if (cmd_i.map_mul || cmd_i.sq_mul) begin
      p0_q <= $signed(m0_full[63:0]);
      p1_q <= $signed(m1_full[63:0]);
      p2_q <= $signed(m2_full[63:0]);
    end
    if (cmd_i.map_add) begin
      cr_q <= sat32(map_re);
      ci_q <= sat32(map_im);
      zr_q <= sat32(map_re);
      zi_q <= sat32(map_im);
      n_q  <= 8'd0;
    end
    if (cmd_i.update) begin
      if (sts_o.stop) begin
        iter_q <= n_q;
        esc_q  <= esc;
      end else begin
        zr_q <= sat32(nr_sum);
        zi_q <= sat32(ni_sum);
        n_q  <= n_q + 8'd1;
      end
    end
  end

  assign iterations_o = iter_q;
  assign escaped_o    = esc_q;
  assign red_o        = iter_q * PAL_RED;
  assign green_o      = iter_q * PAL_GREEN;
  assign blue_o       = iter_q * PAL_BLUE;

endmodule

// ===== rtl/etfp_ctrl.sv =====
// Controller state machine: sequences mapping, squaring and update steps.
// Depends on etfp_pkg and the assertion macro header.
`include "escape_time_fractal_pixel_assert.svh"

module etfp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  output logic                 done_o,
  input  etfp_pkg::etfp_sts_t  sts_i,
  output etfp_pkg::etfp_cmd_t  cmd_o
);
  import etfp_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MAP_MUL = 3'd1;
  localparam logic [2:0] S_MAP_ADD = 3'd2;
  localparam logic [2:0] S_SQ      = 3'd3;
  localparam logic [2:0] S_UPD     = 3'd4;

  logic [2:0] state_q, state_d;
  logic       done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MAP_MUL;
        end
      end
      S_MAP_MUL: begin
        cmd_o.map_mul = 1'b1;
        state_d       = S_MAP_ADD;
      end
      S_MAP_ADD: begin
        cmd_o.map_add = 1'b1;
        state_d       = S_SQ;
      end
      S_SQ: begin
        cmd_o.sq_mul = 1'b1;
        state_d      = S_UPD;
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        if (sts_i.stop) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_SQ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  `ETFP_ASSERT_IMP(a_done_in_idle, done_q, state_q == S_IDLE, "result strobe outside idle")
  `ETFP_ASSERT_NXT(a_done_single, done_q, !done_q, "result strobe longer than one cycle")
  `ETFP_ASSERT_NXT(a_start_maps, start_i && !busy_o, state_q == S_MAP_MUL, "start not taken")
  `ETFP_ASSERT_NXT(a_sq_then_upd, state_q == S_SQ, state_q == S_UPD, "square not followed by update")

endmodule
